### hdl/wildcard_line_search_column_macros.svh
// Assertion macros used by the checker file of the line search block.
`ifndef WILDCARD_LINE_SEARCH_COLUMN_MACROS_SVH
`define WILDCARD_LINE_SEARCH_COLUMN_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define WLSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define WLSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/wlsc_pkg.sv
`timescale 1ns / 1ps

package wlsc_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int COLUMN_W      = 16;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_PATTERN_LOW  = 8'd0;
   localparam logic [7:0] CSR_PATTERN_HIGH = 8'd1;
   localparam logic [7:0] CSR_PATTERN_LEN  = 8'd2;
   localparam logic [7:0] CSR_IGNORE_CASE  = 8'd3;

   // Character codes
   localparam logic [7:0] HIGH_BIT    = 8'h80;
   localparam logic [7:0] DOT_CHAR    = 8'h2E;
   localparam logic [7:0] TAB_CHAR    = 8'h09;
   localparam logic [7:0] PRINT_LOW   = 8'h20;
   localparam logic [7:0] PRINT_HIGH  = 8'h7E;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [1:0] TAB_ROUND   = 2'd3;
   localparam logic [COLUMN_W-1:0] COLUMN_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] line_char;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [COLUMN_W-1:0] start_column;
   } rsp_type;

   typedef struct packed {
      logic [8*PATTERN_BYTES-1:0] pattern;
      logic                       ignore_case;
   } match_cfg_type;

   typedef struct packed {
      logic                hit;
      logic [COLUMN_W-1:0] column;
   } match_result_type;

   // ASCII lower case to upper case when folding is on
   function automatic logic [7:0] fold(input logic [7:0] c, input logic ignore_case);
      if (ignore_case && c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   // Display column of the byte after one of width given by ch
   function automatic logic [COLUMN_W-1:0] next_column(input logic [COLUMN_W-1:0] col,
                                                        input logic [7:0] ch);
      logic [COLUMN_W+1:0] x;
      logic [7:0]          c7;
      x  = {2'b00, col} + 18'd1;
      c7 = ch & ~HIGH_BIT;
      if ((ch & HIGH_BIT) != 8'h00) begin
         x = x + 18'd2;
      end
      if (c7 < PRINT_LOW || c7 > PRINT_HIGH) begin
         if (c7 == TAB_CHAR) begin
            x = (x + 18'(TAB_ROUND)) & ~18'(TAB_ROUND);
         end else begin
            x = x + 18'd1;
         end
      end
      return (x > 18'(COLUMN_MAX)) ? COLUMN_MAX : x[COLUMN_W-1:0];
   endfunction

endpackage

### hdl/wlsc_match.sv
`timescale 1ns / 1ps

// Parallel compare of the pattern against the character window, one lane
// per pattern position, plus the start column of the candidate match.
module wlsc_match #(
   parameter int MAX_PATTERN = 16,
   localparam int LEN_W = $clog2(MAX_PATTERN + 1),
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic [7:0]                        win_char [MAX_PATTERN],
   input  logic [wlsc_pkg::COLUMN_W-1:0]     win_col  [MAX_PATTERN],
   input  logic [LEN_W-1:0]                  len,
   input  wlsc_pkg::match_cfg_type           cfg,
   output wlsc_pkg::match_result_type        result
);

   logic [MAX_PATTERN-1:0] lane_ok;
   logic [LEN_W-1:0]       col_idx;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
      logic [7:0]       pat_c;
      logic [7:0]       win_c;
      logic [LEN_W-1:0] idx;

      // Pattern positions past the register bytes read as zero
      if (j < wlsc_pkg::PATTERN_BYTES) begin : g_pat
         assign pat_c = wlsc_pkg::fold(cfg.pattern[8*j +: 8], cfg.ignore_case);
      end else begin : g_zero
         assign pat_c = 8'h00;
      end

      // Pattern char j lines up with window entry len-1-j (entry 0 newest)
      assign idx     = len - LEN_W'(j) - LEN_W'(1);
      assign win_c   = wlsc_pkg::fold(win_char[idx[IDX_W-1:0]], cfg.ignore_case);
      assign lane_ok[j] = (32'(len) <= j) || (pat_c == wlsc_pkg::DOT_CHAR) ||
                          (win_c == pat_c);
   end

   assign col_idx       = len - LEN_W'(1);
   assign result.hit    = &lane_ok;
   assign result.column = win_col[col_idx[IDX_W-1:0]];

endmodule

### hdl/wildcard_line_search_column.sv
`timescale 1ns / 1ps
// Wildcard substring search over a streamed line, giving the display column.
// Throughput: one character per cycle while the result slot is free, set by the combinational window compare.
// A character is registered in the input stage and compared there; its result is registered in the result slot.
// Reset (synchronous): config to defaults, line state and window cleared,
// both pipeline valids low; no clearing pass, ready right after reset.
module wildcard_line_search_column #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wlsc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wlsc_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_index,
   input  logic [63:0]          csr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int COL_W = wlsc_pkg::COLUMN_W;

   // Configuration registers
   logic [63:0] pattern_low_ff,  pattern_low_in;
   logic [63:0] pattern_high_ff, pattern_high_in;
   logic [4:0]  pattern_len_ff,  pattern_len_in;
   logic        ignore_case_ff,  ignore_case_in;

   // Input stage
   logic              s1_valid_ff, s1_valid_in;
   wlsc_pkg::req_type s1_data_ff,  s1_data_in;

   // Line state
   logic [7:0]       win_char_ff [MAX_PATTERN];
   logic [7:0]       win_char_in [MAX_PATTERN];
   logic [7:0]       win_char_sh [MAX_PATTERN];
   logic [COL_W-1:0] win_col_ff  [MAX_PATTERN];
   logic [COL_W-1:0] win_col_in  [MAX_PATTERN];
   logic [COL_W-1:0] win_col_sh  [MAX_PATTERN];
   logic [COL_W-1:0] run_col_ff,  run_col_in;
   logic [LEN_W-1:0] seen_ff,     seen_in;
   logic             done_ff,     done_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   wlsc_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   logic                       advance;
   logic                       req_beat;
   logic [LEN_W-1:0]           len;
   logic [LEN_W-1:0]           seen_inc;
   logic                       res_found;
   logic                       produce;
   wlsc_pkg::match_cfg_type    match_cfg;
   wlsc_pkg::match_result_type match_res;

   // Config write decode
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      pattern_len_in  = pattern_len_ff;
      ignore_case_in  = ignore_case_ff;
      if (csr_valid) begin
         case (csr_index)
            wlsc_pkg::CSR_PATTERN_LOW:  pattern_low_in  = csr_data;
            wlsc_pkg::CSR_PATTERN_HIGH: pattern_high_in = csr_data;
            wlsc_pkg::CSR_PATTERN_LEN:  pattern_len_in  = csr_data[4:0];
            wlsc_pkg::CSR_IGNORE_CASE:  ignore_case_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // Handshake: the input stage moves on whenever the result slot is empty or being read
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Effective pattern length, capped at the window depth
   always_comb begin
      if (32'(pattern_len_ff) > MAX_PATTERN) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(pattern_len_ff);
      end
   end

   assign seen_inc = (seen_ff == LEN_W'(MAX_PATTERN)) ? seen_ff : seen_ff + LEN_W'(1);

   // Window after taking in the current character
   always_comb begin
      win_char_sh[0] = s1_data_ff.line_char;
      win_col_sh[0]  = run_col_ff;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_char_sh[k] = win_char_ff[k-1];
         win_col_sh[k]  = win_col_ff[k-1];
      end
   end

   assign match_cfg.pattern     = {pattern_high_ff, pattern_low_ff};
   assign match_cfg.ignore_case = ignore_case_ff;

   wlsc_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .win_char (win_char_sh),
      .win_col  (win_col_sh),
      .len      (len),
      .cfg      (match_cfg),
      .result   (match_res)
   );

   // Empty pattern matches at column 0 on the first character only
   assign res_found = !done_ff &&
                      ((len == '0) ? (seen_ff == '0) : ((seen_inc >= len) && match_res.hit));
   assign produce   = advance && !done_ff && (res_found || s1_data_ff.end_of_line);

   // Line state update
   always_comb begin
      win_char_in = win_char_ff;
      win_col_in  = win_col_ff;
      run_col_in  = run_col_ff;
      seen_in     = seen_ff;
      done_in     = done_ff;
      if (advance) begin
         if (!done_ff) begin
            if (len != '0) begin
               win_char_in = win_char_sh;
               win_col_in  = win_col_sh;
            end
            seen_in    = seen_inc;
            run_col_in = wlsc_pkg::next_column(run_col_ff, s1_data_ff.line_char);
            done_in    = res_found;
         end
         if (s1_data_ff.end_of_line) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
               win_char_in[k] = 8'h00;
               win_col_in[k]  = '0;
            end
            run_col_in = '0;
            seen_in    = '0;
            done_in    = 1'b0;
         end
      end
   end

   // Result slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (produce) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.found        = res_found;
         rsp_data_in.start_column = (res_found && len != '0) ? match_res.column : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control and line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= 5'd1;
         ignore_case_ff  <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         run_col_ff      <= '0;
         seen_ff         <= '0;
         done_ff         <= 1'b0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_char_ff[k] <= 8'h00;
            win_col_ff[k]  <= '0;
         end
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         pattern_len_ff  <= pattern_len_in;
         ignore_case_ff  <= ignore_case_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         run_col_ff      <= run_col_in;
         seen_ff         <= seen_in;
         done_ff         <= done_in;
         win_char_ff     <= win_char_in;
         win_col_ff      <= win_col_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hdl/wlsc_checker.sv
`timescale 1ns / 1ps
`include "wildcard_line_search_column_macros.svh"

// Port-level checks on the line search block
module wlsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wlsc_pkg::rsp_type rsp_data
);

   // A stalled result beat holds
   `WLSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Not-found results carry column zero
   `WLSC_ASSERT_IMP(a_miss_col, clock, reset, rsp_valid && !rsp_data.found, rsp_data.start_column == '0, "not-found result with nonzero column")

   // Reset empties the result slot
   `WLSC_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // Nothing comes out in the cycle right after reset without an input beat
   `WLSC_ASSERT_NXT(a_no_early_rsp, clock, 1'b0, reset, !rsp_valid ##1 (!rsp_valid || $past(req_valid && req_ready)), "result before any input beat")

endmodule

bind wildcard_line_search_column wlsc_checker u_wlsc_checker (.*);
